// File: rtl/scsa_pkg.sv
`default_nettype none
package scsa_pkg;

  // default sizing of the allocator
  localparam int SIZE_SHIFT_DEF     = 5;
  localparam int SIZE_CLASSES_DEF   = 128;
  localparam int FORMATS_DEF        = 18;
  localparam int SLOT_RECORDS_DEF   = 4096;
  localparam int BUFFER_RECORDS_DEF = 32;

  // internal field widths
  localparam int IDX_W  = 8;   // buffer index carried by the walk token
  localparam int SIZE_W = 17;  // rounded size, capacity and bump offset
  localparam int FMT_W  = 5;
  localparam int OFS_W  = 16;

  // opcodes
  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_REL = 2'd1;
  localparam logic [1:0] OP_CLR = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_BAD_SIZE   = 3'd1;
  localparam logic [2:0] STAT_NO_SLOT    = 3'd2;
  localparam logic [2:0] STAT_NO_BUF     = 3'd3;
  localparam logic [2:0] STAT_NOT_ISSUED = 3'd4;

  // token handed from cell to cell during a buffer walk
  typedef struct packed {
    logic [FMT_W-1:0]  fmt;
    logic [SIZE_W-1:0] size;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [OFS_W-1:0]  start;
  } tok_t;

  // buffer open command broadcast to the cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [FMT_W-1:0]  fmt;
    logic [SIZE_W-1:0] cap;
    logic [SIZE_W-1:0] used;
  } bwr_t;

endpackage
`default_nettype wire

// File: rtl/scsa_if.sv
`default_nettype none
// request channel
interface scsa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  format;
  logic [15:0] request_size;
  logic [11:0] slot_id;
  modport source (output valid, opcode, format, request_size, slot_id, input ready);
  modport sink   (input valid, opcode, format, request_size, slot_id, output ready);
endinterface

// result channel
interface scsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] granted_slot;
  logic [4:0]  buffer_index;
  logic [15:0] slot_start;
  logic [12:0] slot_length;
  logic        opened_buffer;
  logic [15:0] buffer_capacity;
  modport source (output valid, status, granted_slot, buffer_index, slot_start, slot_length,
                  opened_buffer, buffer_capacity, input ready);
  modport sink   (input valid, status, granted_slot, buffer_index, slot_start, slot_length,
                  opened_buffer, buffer_capacity, output ready);
endinterface
`default_nettype wire

// File: rtl/scsa_ram.sv
`default_nettype none
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/scsa_cell.sv
`default_nettype none
module scsa_cell import scsa_pkg::*; #(
  parameter int ID = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_in_vld,
  input  tok_t             tok_in,
  input  logic             open,
  input  bwr_t             bwr,
  output logic             tok_out_vld,
  output tok_t             tok_out,
  output logic [FMT_W-1:0] fmt,
  output logic [SIZE_W-1:0] cap
);

  logic [SIZE_W-1:0] used;
  logic              hit;
  tok_t              tok_next;

  // claim the token when this buffer matches the format and has room
  always_comb begin
    hit = tok_in_vld && !tok_in.found && open && (fmt == tok_in.fmt) &&
          (cap >= used) && ((cap - used) >= tok_in.size);
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.idx   = IDX_W'(ID);
      tok_next.start = OFS_W'(used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_vld <= 1'b0;
    end else begin
      tok_out_vld <= tok_in_vld;
    end
    // hand the token to the next older buffer
    tok_out <= tok_next;
    // open this buffer, or bump its offset on a claim
    if (bwr.en && (bwr.idx == IDX_W'(ID))) begin
      fmt  <= bwr.fmt;
      cap  <= bwr.cap;
      used <= bwr.used;
    end else if (hit) begin
      used <= used + tok_in.size;
    end
  end

endmodule
`default_nettype wire

// File: rtl/size_class_slot_allocator.sv
`default_nettype none
// Channel | Role   | Beat contents
// req     | sink   | opcode, format, request_size, slot_id
// rsp     | source | status, granted_slot, buffer_index, slot_start, slot_length,
//         |        | opened_buffer, buffer_capacity
// apb     | slave  | default_buffer_capacity at byte address 0
//
// One request at a time. A get pops a free list if it can; else it walks the buffer
// cells, with the token passing one cell per cycle. A release reads the slot record,
// checks it and pushes the slot onto its free list.
// After reset and for each clear the free list heads are swept, and no request is
// taken meanwhile.
// A result waits in the output register while rsp is stalled; the next request is
// taken only once the block is back in idle.
module size_class_slot_allocator import scsa_pkg::*; #(
  parameter int SIZE_SHIFT     = SIZE_SHIFT_DEF,
  parameter int SIZE_CLASSES   = SIZE_CLASSES_DEF,
  parameter int FORMATS        = FORMATS_DEF,
  parameter int SLOT_RECORDS   = SLOT_RECORDS_DEF,
  parameter int BUFFER_RECORDS = BUFFER_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  scsa_req_if.sink    req,
  scsa_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW     = (SLOT_RECORDS > 1) ? $clog2(SLOT_RECORDS) : 1;
  localparam int BW     = (BUFFER_RECORDS > 1) ? $clog2(BUFFER_RECORDS) : 1;
  localparam int CW     = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int LDEPTH = FORMATS * SIZE_CLASSES;
  localparam int LW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int MAXSZ  = SIZE_CLASSES << SIZE_SHIFT;
  localparam logic [SIZE_W-1:0] MASK = SIZE_W'((1 << SIZE_SHIFT) - 1);
  localparam logic [2:0] ADDR_DEF_CAP = 3'd0;

  typedef struct packed {
    logic [BW-1:0]     bidx;
    logic [OFS_W-1:0]  start;
    logic [SIZE_W-1:0] len;
    logic [SW-1:0]     nxt;
    logic              nxt_vld;
    logic              on_free;
  } srec_t;

  typedef struct packed {
    logic          vld;
    logic [SW-1:0] head;
  } fle_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_GFL_RD, S_GFL, S_SREAD, S_POP, S_WALK,
    S_RREAD, S_RCHK, S_RFL_RD, S_RFL, S_OUT
  } state_t;

  state_t            state;
  logic [15:0]       def_cap;
  logic [SW:0]       slots_issued;
  logic [BW:0]       buffers_opened;
  logic [LW-1:0]     clr_cnt;
  logic              clr_reply;
  logic [FMT_W-1:0]  op_fmt;
  logic [SIZE_W-1:0] op_size;
  logic [LW-1:0]     li;
  logic [11:0]       op_id;
  logic [SW-1:0]     sel_slot;
  logic              launch_vld;
  tok_t              launch;

  // result staging and output register
  logic [2:0]  res_status;
  logic [11:0] res_slot;
  logic [4:0]  res_bidx;
  logic [15:0] res_start;
  logic [12:0] res_len;
  logic        res_opened;
  logic [15:0] res_cap;
  logic        out_vld;
  logic [2:0]  out_status;
  logic [11:0] out_slot;
  logic [4:0]  out_bidx;
  logic [15:0] out_start;
  logic [12:0] out_len;
  logic        out_opened;
  logic [15:0] out_cap;

  // memories
  logic          fl_we;
  logic [LW-1:0] fl_waddr;
  fle_t          fl_wdata;
  fle_t          fl_rdata;
  logic          sr_we;
  logic [SW-1:0] sr_waddr;
  srec_t         sr_wdata;
  srec_t         sr_rdata;

  // cell chain
  logic [BUFFER_RECORDS:0] link_vld;
  tok_t                    link [BUFFER_RECORDS+1];
  logic [FMT_W-1:0]        cell_fmt [BUFFER_RECORDS];
  logic [SIZE_W-1:0]       cell_cap [BUFFER_RECORDS];
  logic [BUFFER_RECORDS-1:0] cell_open;
  bwr_t                    bwr;

  // request decode
  logic              acc;
  logic [SIZE_W-1:0] size_c;
  logic [CW-1:0]     cls_c;
  logic              bad_c;
  logic [LW-1:0]     li_c;
  logic              rel_bad_c;
  logic [CW-1:0]     rcls;
  logic [LW-1:0]     rli;
  logic [BW-1:0]     hit_idx;
  logic [SIZE_W-1:0] new_cap;
  logic              walk_done;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    size_c    = ({1'b0, req.request_size} + MASK) & ~MASK;
    cls_c     = CW'((size_c >> SIZE_SHIFT) - SIZE_W'(1));
    bad_c     = (32'(req.format) >= 32'(FORMATS)) || (size_c == '0) ||
                (32'(size_c) > 32'(MAXSZ));
    li_c      = LW'(32'(req.format) * SIZE_CLASSES + 32'(cls_c));
    rel_bad_c = (32'(req.slot_id) >= 32'(slots_issued)) ||
                (32'(req.slot_id) >= 32'(SLOT_RECORDS));
    rcls      = CW'((sr_rdata.len >> SIZE_SHIFT) - SIZE_W'(1));
    rli       = LW'(32'(cell_fmt[sr_rdata.bidx]) * SIZE_CLASSES + 32'(rcls));
    hit_idx   = BW'(link[0].idx);
    new_cap   = ({1'b0, def_cap} > op_size) ? {1'b0, def_cap} : op_size;
    walk_done = (state == S_WALK) && link_vld[0];
  end

  // memory write ports and buffer open command
  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = li;
    fl_wdata = '0;
    sr_we    = 1'b0;
    sr_waddr = sel_slot;
    sr_wdata = sr_rdata;
    bwr      = '0;
    case (state)
      S_CLR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_cnt;
      end
      S_POP: begin
        fl_we            = 1'b1;
        fl_wdata.vld     = sr_rdata.nxt_vld;
        fl_wdata.head    = sr_rdata.nxt;
        sr_we            = 1'b1;
        sr_wdata.on_free = 1'b0;
        sr_wdata.nxt_vld = 1'b0;
      end
      S_RFL: begin
        fl_we            = 1'b1;
        fl_wdata.vld     = 1'b1;
        fl_wdata.head    = SW'(op_id);
        sr_we            = 1'b1;
        sr_wdata.nxt     = fl_rdata.head;
        sr_wdata.nxt_vld = fl_rdata.vld;
        sr_wdata.on_free = 1'b1;
      end
      S_WALK: begin
        sr_waddr         = SW'(slots_issued);
        sr_wdata.len     = op_size;
        sr_wdata.nxt     = '0;
        sr_wdata.nxt_vld = 1'b0;
        sr_wdata.on_free = 1'b0;
        if (walk_done && link[0].found) begin
          sr_we          = 1'b1;
          sr_wdata.bidx  = hit_idx;
          sr_wdata.start = link[0].start;
        end else if (walk_done && (32'(buffers_opened) < 32'(BUFFER_RECORDS))) begin
          sr_we          = 1'b1;
          sr_wdata.bidx  = BW'(buffers_opened);
          sr_wdata.start = '0;
          bwr.en         = 1'b1;
          bwr.idx        = IDX_W'(buffers_opened);
          bwr.fmt        = op_fmt;
          bwr.cap        = new_cap;
          bwr.used       = op_size;
        end
      end
      default: ;
    endcase
  end

  scsa_ram #(.WIDTH($bits(fle_t)), .DEPTH(LDEPTH)) u_fl_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (li),
    .rdata (fl_rdata)
  );

  scsa_ram #(.WIDTH($bits(srec_t)), .DEPTH(SLOT_RECORDS)) u_slot_ram (
    .clk   (clk),
    .we    (sr_we),
    .waddr (sr_waddr),
    .wdata (sr_wdata),
    .raddr (sel_slot),
    .rdata (sr_rdata)
  );

  // buffer cells, newest at the top of the chain
  assign link_vld[BUFFER_RECORDS] = launch_vld;
  assign link[BUFFER_RECORDS]     = launch;

  for (genvar i = 0; i < BUFFER_RECORDS; i++) begin : g_cell
    assign cell_open[i] = (32'(buffers_opened) > 32'(i));
    scsa_cell #(.ID(i)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .tok_in_vld  (link_vld[i+1]),
      .tok_in      (link[i+1]),
      .open        (cell_open[i]),
      .bwr         (bwr),
      .tok_out_vld (link_vld[i]),
      .tok_out     (link[i]),
      .fmt         (cell_fmt[i]),
      .cap         (cell_cap[i])
    );
  end

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DEF_CAP) ? {16'd0, def_cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_cap <= 16'd8192;
    end else if (psel && penable && pwrite && (paddr == ADDR_DEF_CAP)) begin
      def_cap <= pwdata[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      clr_cnt        <= '0;
      clr_reply      <= 1'b0;
      slots_issued   <= '0;
      buffers_opened <= '0;
      launch_vld     <= 1'b0;
      out_vld        <= 1'b0;
    end else begin
      // launch a walk token when the free list comes up empty
      launch_vld <= (state == S_GFL) && !fl_rdata.vld &&
                    (32'(slots_issued) < 32'(SLOT_RECORDS));
      // load the output register, or drop the beat once taken
      if ((state == S_OUT) && (!out_vld || rsp.ready)) begin
        out_vld <= 1'b1;
      end else if (out_vld && rsp.ready) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (32'(clr_cnt) == LDEPTH - 1) begin
            clr_cnt    <= '0;
            res_status <= STAT_OK;
            res_slot   <= '0;
            res_bidx   <= '0;
            res_start  <= '0;
            res_len    <= '0;
            res_opened <= 1'b0;
            res_cap    <= '0;
            state      <= clr_reply ? S_OUT : S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + LW'(1);
          end
        end
        S_IDLE: begin
          if (acc) begin
            op_fmt     <= req.format;
            op_size    <= size_c;
            li         <= li_c;
            op_id      <= req.slot_id;
            sel_slot   <= SW'(req.slot_id);
            res_slot   <= '0;
            res_bidx   <= '0;
            res_start  <= '0;
            res_len    <= '0;
            res_opened <= 1'b0;
            res_cap    <= '0;
            case (req.opcode)
              OP_GET: begin
                if (bad_c) begin
                  res_status <= STAT_BAD_SIZE;
                  state      <= S_OUT;
                end else begin
                  state <= S_GFL_RD;
                end
              end
              OP_REL: begin
                if (rel_bad_c) begin
                  res_status <= STAT_NOT_ISSUED;
                  state      <= S_OUT;
                end else begin
                  state <= S_RREAD;
                end
              end
              OP_CLR: begin
                slots_issued   <= '0;
                buffers_opened <= '0;
                clr_reply      <= 1'b1;
                state          <= S_CLR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_GFL_RD: state <= S_GFL;
        S_GFL: begin
          // pop the free list, else fail if no slot record is left, else walk the buffers of this format
          if (fl_rdata.vld) begin
            sel_slot <= fl_rdata.head;
            state    <= S_SREAD;
          end else if (32'(slots_issued) >= 32'(SLOT_RECORDS)) begin
            res_status <= STAT_NO_SLOT;
            state      <= S_OUT;
          end else begin
            launch.fmt   <= op_fmt;
            launch.size  <= op_size;
            launch.found <= 1'b0;
            launch.idx   <= '0;
            launch.start <= '0;
            state        <= S_WALK;
          end
        end
        S_SREAD: state <= S_POP;
        S_POP: begin
          res_status <= STAT_OK;
          res_slot   <= 12'(sel_slot);
          res_bidx   <= 5'(sr_rdata.bidx);
          res_start  <= sr_rdata.start;
          res_len    <= 13'(sr_rdata.len);
          res_cap    <= 16'(cell_cap[sr_rdata.bidx]);
          state      <= S_OUT;
        end
        S_WALK: begin
          if (walk_done) begin
            state <= S_OUT;
            if (link[0].found) begin
              slots_issued <= slots_issued + 1'b1;
              res_status   <= STAT_OK;
              res_slot     <= 12'(slots_issued);
              res_bidx     <= 5'(hit_idx);
              res_start    <= link[0].start;
              res_len      <= 13'(op_size);
              res_cap      <= 16'(cell_cap[hit_idx]);
            end else if (32'(buffers_opened) < 32'(BUFFER_RECORDS)) begin
              slots_issued   <= slots_issued + 1'b1;
              buffers_opened <= buffers_opened + 1'b1;
              res_status     <= STAT_OK;
              res_slot       <= 12'(slots_issued);
              res_bidx       <= 5'(buffers_opened);
              res_start      <= '0;
              res_len        <= 13'(op_size);
              res_opened     <= 1'b1;
              res_cap        <= 16'(new_cap);
            end else begin
              res_status <= STAT_NO_BUF;
            end
          end
        end
        S_RREAD: state <= S_RCHK;
        S_RCHK: begin
          if (sr_rdata.on_free) begin
            res_status <= STAT_NOT_ISSUED;
            state      <= S_OUT;
          end else begin
            li    <= rli;
            state <= S_RFL_RD;
          end
        end
        S_RFL_RD: state <= S_RFL;
        S_RFL: begin
          res_status <= STAT_OK;
          res_slot   <= op_id;
          res_bidx   <= 5'(sr_rdata.bidx);
          res_start  <= sr_rdata.start;
          res_len    <= 13'(sr_rdata.len);
          res_cap    <= 16'(cell_cap[sr_rdata.bidx]);
          state      <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_vld || rsp.ready) begin
            out_status <= res_status;
            out_slot   <= res_slot;
            out_bidx   <= res_bidx;
            out_start  <= res_start;
            out_len    <= res_len;
            out_opened <= res_opened;
            out_cap    <= res_cap;
            clr_reply  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid           = out_vld;
  assign rsp.status          = out_status;
  assign rsp.granted_slot    = out_slot;
  assign rsp.buffer_index    = out_bidx;
  assign rsp.slot_start      = out_start;
  assign rsp.slot_length     = out_len;
  assign rsp.opened_buffer   = out_opened;
  assign rsp.buffer_capacity = out_cap;

  // checks
  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    32'(slots_issued) <= 32'(SLOT_RECORDS)) else $error("slot count past pool size");

  a_bufs_bound: assert property (@(posedge clk) disable iff (rst)
    32'(buffers_opened) <= 32'(BUFFER_RECORDS)) else $error("buffer count past pool size");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(link_vld) <= 1) else $error("more than one walk token in the chain");

  a_open_ok: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_opened) |-> (out_status == STAT_OK))
    else $error("buffer opened on an error result");

  a_walk_idle: assert property (@(posedge clk) disable iff (rst)
    (link_vld != '0) |-> (state == S_WALK)) else $error("walk token outside a walk");

endmodule
`default_nettype wire

// File: tb/tb_size_class_slot_allocator.sv
`timescale 1ns / 1ps
module tb_size_class_slot_allocator;
  import scsa_pkg::*;

  localparam int SHIFT      = SIZE_SHIFT_DEF;
  localparam int CLASSES    = SIZE_CLASSES_DEF;
  localparam int NFMT       = FORMATS_DEF;
  localparam int NSLOTS     = SLOT_RECORDS_DEF;
  localparam int NBUFS      = BUFFER_RECORDS_DEF;
  localparam int MAX_SIZE   = CLASSES << SHIFT;
  localparam int SWEEP_WAIT = NFMT * CLASSES + 100;
  localparam int STALL_LEN  = 300;
  localparam int WDOG_LIMIT = 20000;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot;
    logic [4:0]  bidx;
    logic [15:0] start;
    logic [12:0] len;
    logic        opened;
    logic [15:0] cap;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scsa_req_if req_ch();
  scsa_rsp_if rsp_ch();

  size_class_slot_allocator i_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // allocator shadow state
  logic [11:0] fl_head [NFMT*CLASSES];
  bit          fl_valid [NFMT*CLASSES];
  logic [4:0]  sl_buf [NSLOTS];
  logic [16:0] sl_start [NSLOTS];
  logic [12:0] sl_len [NSLOTS];
  logic [11:0] sl_next [NSLOTS];
  bit          sl_nv [NSLOTS];
  bit          sl_free [NSLOTS];
  logic [4:0]  bf_fmt [NBUFS];
  logic [16:0] bf_cap [NBUFS];
  logic [16:0] bf_used [NBUFS];
  logic [4:0]  bf_next [NBUFS];
  bit          bf_nv [NBUFS];
  logic [4:0]  fmt_head [NFMT];
  bit          fmt_valid [NFMT];
  int          issued_cnt;
  int          opened_cnt;
  logic [15:0] dflt_cap = 16'd8192;

  alloc_result_t expected_results[$];
  int  mismatches = 0;
  bit  idling = 1'b1;
  bit  hold_rsp = 1'b0;
  int  quiet_cycles = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < NFMT*CLASSES; i++) fl_valid[i] = 1'b0;
    for (int i = 0; i < NFMT; i++) fmt_valid[i] = 1'b0;
    issued_cnt = 0;
    opened_cnt = 0;
  endfunction

  function automatic alloc_result_t grant(int s, bit opened);
    alloc_result_t r;
    r.status = STAT_OK;
    r.slot   = s[11:0];
    r.bidx   = sl_buf[s];
    r.start  = sl_start[s][15:0];
    r.len    = sl_len[s];
    r.opened = opened;
    r.cap    = bf_cap[sl_buf[s]][15:0];
    return r;
  endfunction

  function automatic alloc_result_t fail_result(logic [2:0] st);
    alloc_result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic void new_slot(int s, int b, int start, int size);
    sl_buf[s]   = b[4:0];
    sl_start[s] = start[16:0];
    sl_len[s]   = size[12:0];
    sl_nv[s]    = 1'b0;
    sl_free[s]  = 1'b0;
  endfunction

  function automatic alloc_result_t predict_get(int fmt, int req);
    int size, li, s, b, cap;
    bit bv;
    size = (req + (1 << SHIFT) - 1) & ~((1 << SHIFT) - 1);
    if (fmt >= NFMT || size == 0 || size > MAX_SIZE) return fail_result(STAT_BAD_SIZE);
    li = fmt * CLASSES + (size >> SHIFT) - 1;
    // pop the matching free list first
    if (fl_valid[li]) begin
      s = fl_head[li];
      fl_head[li]  = sl_next[s];
      fl_valid[li] = sl_nv[s];
      sl_free[s] = 1'b0;
      sl_nv[s]   = 1'b0;
      return grant(s, 1'b0);
    end
    if (issued_cnt >= NSLOTS) return fail_result(STAT_NO_SLOT);
    // bump in the newest buffer with room
    b  = fmt_head[fmt];
    bv = fmt_valid[fmt];
    while (bv) begin
      if (bf_cap[b] - bf_used[b] >= size) begin
        s = issued_cnt++;
        new_slot(s, b, bf_used[b], size);
        bf_used[b] += size[16:0];
        return grant(s, 1'b0);
      end
      bv = bf_nv[b];
      b  = bf_next[b];
    end
    // open a fresh buffer
    if (opened_cnt >= NBUFS) return fail_result(STAT_NO_BUF);
    b = opened_cnt++;
    cap = (dflt_cap > size) ? dflt_cap : size;
    bf_fmt[b]  = fmt[4:0];
    bf_cap[b]  = cap[16:0];
    bf_used[b] = size[16:0];
    bf_next[b] = fmt_head[fmt];
    bf_nv[b]   = fmt_valid[fmt];
    fmt_head[fmt]  = b[4:0];
    fmt_valid[fmt] = 1'b1;
    s = issued_cnt++;
    new_slot(s, b, 0, size);
    return grant(s, 1'b1);
  endfunction

  function automatic alloc_result_t predict_release(int id);
    int li;
    if (id >= issued_cnt || sl_free[id]) return fail_result(STAT_NOT_ISSUED);
    li = bf_fmt[sl_buf[id]] * CLASSES + (sl_len[id] >> SHIFT) - 1;
    sl_next[id] = fl_head[li];
    sl_nv[id]   = fl_valid[li];
    sl_free[id] = 1'b1;
    fl_head[li]  = id[11:0];
    fl_valid[li] = 1'b1;
    return grant(id, 1'b0);
  endfunction

  // drive one request beat and record what it should return
  task automatic send_item(logic [1:0] op, logic [4:0] fmt, logic [15:0] sz, logic [11:0] id);
    if (idling && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 5)) @(negedge clk);
    @(negedge clk);
    req_ch.opcode       = op;
    req_ch.format       = fmt;
    req_ch.request_size = sz;
    req_ch.slot_id      = id;
    req_ch.valid        = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    case (op)
      OP_GET: expected_results.push_back(predict_get(fmt, sz));
      OP_REL: expected_results.push_back(predict_release(id));
      OP_CLR: begin
        clear_shadow();
        expected_results.push_back(fail_result(STAT_OK));
      end
      default: ;
    endcase
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] v);
    wait_drain();
    repeat (SWEEP_WAIT) @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = '0; pwdata = {16'd0, v};
    @(negedge clk) penable = 1'b1;
    @(negedge clk) begin
      penable = 1'b0; pwrite = 1'b0;
    end
    dflt_cap = v;
    // read back
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== v) begin
      mismatches++;
      if (mismatches <= 10) $display("capacity readback: expected %0d got %0d", v, prdata[15:0]);
    end
    @(negedge clk) begin
      psel = 1'b0; penable = 1'b0;
    end
  endtask

  function automatic logic [15:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 256));
    if (r < 85) return 16'($urandom_range(1, MAX_SIZE));
    if (r < 95) return 16'($urandom_range(MAX_SIZE + 1, 65535));
    return 16'd0;
  endfunction

  function automatic logic [4:0] rand_fmt();
    if ($urandom_range(0, 99) < 92) return 5'($urandom_range(0, NFMT - 1));
    return 5'($urandom_range(NFMT, 31));
  endfunction

  task automatic test_bad_requests();
    send_item(OP_GET, 5'd0, 16'd0, 12'd0);
    send_item(OP_GET, 5'd0, 16'(MAX_SIZE + 1), 12'd0);
    send_item(OP_GET, 5'd3, 16'hFFFF, 12'd0);
    send_item(OP_GET, 5'(NFMT), 16'd32, 12'd0);
    send_item(OP_GET, 5'd31, 16'd1, 12'd0);
    send_item(OP_REL, 5'd0, 16'd0, 12'd0);
    send_item(OP_REL, 5'd31, 16'hFFFF, 12'hFFF);
    send_item(OP_NONE, 5'd31, 16'hFFFF, 12'hFFF);
    send_item(OP_CLR, 5'd0, 16'd0, 12'd0);
  endtask

  task automatic test_get_release();
    send_item(OP_GET, 5'd0, 16'd1, 12'd0);
    send_item(OP_GET, 5'd0, 16'd32, 12'd0);
    send_item(OP_GET, 5'(NFMT - 1), 16'(MAX_SIZE), 12'd0);
    send_item(OP_GET, 5'd5, 16'd33, 12'd0);
    send_item(OP_REL, 5'd0, 16'd0, 12'd1);
    send_item(OP_GET, 5'd0, 16'd20, 12'd0);
    send_item(OP_REL, 5'd0, 16'd0, 12'd3);
    send_item(OP_REL, 5'd0, 16'd0, 12'd3);
    send_item(OP_GET, 5'd5, 16'd64, 12'd0);
  endtask

  task automatic test_capacity_extremes();
    write_capacity(16'd1);
    send_item(OP_CLR, 5'd0, 16'd0, 12'd0);
    send_item(OP_GET, 5'd2, 16'd1, 12'd0);
    send_item(OP_GET, 5'd2, 16'd1, 12'd0);
    write_capacity(16'hFFFF);
    send_item(OP_GET, 5'd2, 16'd100, 12'd0);
    send_item(OP_GET, 5'd2, 16'(MAX_SIZE), 12'd0);
  endtask

  task automatic test_buffer_pool();
    write_capacity(16'd1);
    send_item(OP_CLR, 5'd0, 16'd0, 12'd0);
    for (int i = 0; i <= NBUFS; i++) send_item(OP_GET, 5'(i % NFMT), 16'(MAX_SIZE), 12'd0);
    send_item(OP_GET, 5'd9, 16'd1, 12'd0);
    send_item(OP_REL, 5'd0, 16'd0, 12'd4);
    send_item(OP_GET, 5'd4, 16'(MAX_SIZE - 5), 12'd0);
  endtask

  task automatic test_output_stall();
    hold_rsp = 1'b1;
    for (int i = 0; i < 12; i++) send_item(OP_GET, 5'($urandom_range(0, 3)), rand_size(), 12'd0);
    // pause until everything is back
    wait_drain();
    for (int i = 0; i < 6; i++) send_item(OP_REL, 5'd0, 16'd0, 12'($urandom_range(0, 11)));
  endtask

  task automatic test_random(int n);
    int r;
    logic [11:0] id;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_item(OP_GET, rand_fmt(), rand_size(), 12'($urandom));
      else if (r < 85) begin
        id = (issued_cnt > 0) ? 12'($urandom_range(0, issued_cnt - 1)) : 12'd0;
        send_item(OP_REL, 5'($urandom), 16'($urandom), id);
      end else if (r < 94) send_item(OP_REL, 5'($urandom), 16'($urandom), 12'($urandom));
      else if (r < 98) send_item(OP_NONE, 5'($urandom), 16'($urandom), 12'($urandom));
      else send_item(OP_CLR, 5'($urandom), 16'($urandom), 12'($urandom));
    end
  endtask

  // result sink: random stalls plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready = 1'b0;
        repeat (STALL_LEN) @(negedge clk);
        hold_rsp = 1'b0;
        rsp_ch.ready = 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t act, exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      act = '{rsp_ch.status, rsp_ch.granted_slot, rsp_ch.buffer_index, rsp_ch.slot_start,
              rsp_ch.slot_length, rsp_ch.opened_buffer, rsp_ch.buffer_capacity};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", act);
      end else begin
        exp_r = expected_results.pop_front();
        if (act !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", exp_r, act);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("** size_class_slot_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_GET;
    req_ch.format = '0;
    req_ch.request_size = '0;
    req_ch.slot_id = '0;
    clear_shadow();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_bad_requests();
    test_get_release();
    test_output_stall();
    test_capacity_extremes();
    test_buffer_pool();
    write_capacity(16'd8192);
    test_random(400);
    write_capacity(16'($urandom_range(1, 65535)));
    test_random(350);
    write_capacity(16'($urandom_range(32, 600)));
    test_random(350);
    idling = 1'b0;
    test_random(150);
    wait_drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("** size_class_slot_allocator: PASSED **");
    else $display("** size_class_slot_allocator: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/scsa_pkg.sv
rtl/scsa_if.sv
rtl/scsa_ram.sv
rtl/scsa_cell.sv
rtl/size_class_slot_allocator.sv
tb/tb_size_class_slot_allocator.sv
